>>> rtl/core/hybrid_analysis_fir_bank_macros.svh
// ---------------------------------------------------------------------------
// Hybrid analysis FIR bank assertion macros
// Shared concurrent assertion forms used by the top level.
// ---------------------------------------------------------------------------
`ifndef HYBRID_ANALYSIS_FIR_BANK_MACROS_SVH
`define HYBRID_ANALYSIS_FIR_BANK_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HAFB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HAFB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/hafb_pkg.sv
// ---------------------------------------------------------------------------
// Hybrid analysis FIR bank package
// Types and fixed constants shared by the front, queue and back modules.
// ---------------------------------------------------------------------------
package hafb_pkg;

	localparam int TAPS       = 13;
	localparam int PAIRS      = 6;
	localparam int CPB        = 7;
	localparam int OUT_DEPTH  = 4;
	localparam int OCW        = 3;
	localparam logic [63:0] ROUND_ADD = 64'h0000_0000_4000_0000;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_COEF   = 1'b1
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} bst_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] sre;
		logic signed [31:0] sim;
		logic [3:0]         cband;
		logic [2:0]         ctap;
		logic signed [31:0] cre;
		logic signed [31:0] cim;
	} cmd_t;

	typedef struct packed {
		logic           busy;
		logic [OCW-1:0] fcnt;
	} bstat_t;

endpackage

>>> rtl/core/hafb_front.sv
// ---------------------------------------------------------------------------
// Hybrid analysis FIR bank front end
// Accepts input items, drops out-of-range coefficient writes, and hands
// commands to the queue.
// ---------------------------------------------------------------------------
module hafb_front import hafb_pkg::*; #(
	parameter int MAX_BANDS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               kind,
	input  logic signed [31:0] sample_re,
	input  logic signed [31:0] sample_im,
	input  logic [3:0]         coef_band,
	input  logic [2:0]         coef_tap,
	input  logic signed [31:0] coef_re,
	input  logic signed [31:0] coef_im,
	output logic               q_push,
	output cmd_t               q_cmd,
	input  logic               q_full
);

	logic v_q;
	cmd_t cmd_q;
	logic take;
	logic keep;

	assign full   = v_q && q_full;
	assign take   = push && !full;
	assign keep   = (kind_t'(kind) == KIND_SAMPLE) ||
		(({1'b0, coef_band} < 5'(MAX_BANDS)) && (coef_tap < 3'(CPB)));
	assign q_push = v_q && !q_full;
	assign q_cmd  = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= keep;
		end else if (q_push) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q.kind  <= kind_t'(kind);
			cmd_q.sre   <= sample_re;
			cmd_q.sim   <= sample_im;
			cmd_q.cband <= coef_band;
			cmd_q.ctap  <= coef_tap;
			cmd_q.cre   <= coef_re;
			cmd_q.cim   <= coef_im;
		end
	end

endmodule

>>> rtl/core/hafb_queue.sv
// ---------------------------------------------------------------------------
// Hybrid analysis FIR bank command queue
// Two-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module hafb_queue import hafb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic qfull,
	input  logic rd,
	output logic qvalid,
	output cmd_t rdata
);

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign qfull  = (cnt_q == 2'd2);
	assign qvalid = (cnt_q != 2'd0);
	assign rdata  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

>>> rtl/core/hafb_back.sv
// ---------------------------------------------------------------------------
// Hybrid analysis FIR bank back end
// Holds the window and coefficient memory, runs the complex multiply
// pipeline one tap pair per cycle while the result queue has room, and buffers results.
// ---------------------------------------------------------------------------
module hafb_back import hafb_pkg::*; #(
	parameter int MAX_BANDS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         bands_in_use,
	input  logic               qvalid,
	input  cmd_t               qcmd,
	output logic               qrd,
	output bstat_t             stat,
	output logic               empty,
	input  logic               pop,
	output logic [3:0]         band,
	output logic signed [31:0] out_re,
	output logic signed [31:0] out_im,
	output logic               last
);

	localparam int DEPTH = MAX_BANDS * CPB;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	bst_t st_q, st_d;

	logic signed [31:0] win_re_q [TAPS];
	logic signed [31:0] win_im_q [TAPS];
	logic signed [31:0] wa_re_q [PAIRS];
	logic signed [31:0] wa_im_q [PAIRS];
	logic signed [31:0] wz_re_q [PAIRS];
	logic signed [31:0] wz_im_q [PAIRS];
	logic signed [31:0] nwin_re [TAPS];
	logic signed [31:0] nwin_im [TAPS];

	logic [63:0] cmem [DEPTH];

	logic [3:0] band_q;
	logic [2:0] tap_q;
	logic [4:0] nb;
	logic [4:0] nb_q;
	logic       start;
	logic       issue;
	logic       band_last;
	logic [6:0] raddr_w;
	logic [6:0] waddr_w;

	logic               v_s1, first_s1, fin_s1, last_s1, cen_s1;
	logic [3:0]         band_s1;
	logic signed [32:0] sr_s1, si_s1, dr_s1, di_s1;
	logic [63:0]        coef_s1;

	logic               v_s2, first_s2, fin_s2, last_s2;
	logic [3:0]         band_s2;
	logic signed [64:0] prr_s2, pid_s2, pri_s2, pir_s2;
	logic signed [31:0] ki;

	logic [63:0] acc_re_q, acc_im_q, acc_re_n, acc_im_n, fre, fim;

	logic [3:0]         fb_q [OUT_DEPTH];
	logic signed [31:0] fre_q [OUT_DEPTH];
	logic signed [31:0] fim_q [OUT_DEPTH];
	logic               fl_q [OUT_DEPTH];
	logic [1:0]         fwp_q, frp_q;
	logic [OCW-1:0]     fcnt_q;
	logic               fpush, fpop;

	assign nb = ({1'b0, bands_in_use} > 5'(MAX_BANDS)) ? 5'(MAX_BANDS) : {1'b0, bands_in_use};

	always_comb begin
		for (int i = 0; i < TAPS - 1; i++) begin
			nwin_re[i] = win_re_q[i + 1];
			nwin_im[i] = win_im_q[i + 1];
		end
		nwin_re[TAPS - 1] = qcmd.sre;
		nwin_im[TAPS - 1] = qcmd.sim;
	end

	always_comb begin
		st_d  = st_q;
		qrd   = 1'b0;
		start = 1'b0;
		issue = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (qvalid) begin
					qrd = 1'b1;
					if (qcmd.kind == KIND_SAMPLE && nb != 5'd0) begin
						start = 1'b1;
						st_d  = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				issue = !(tap_q == 3'd0 && fcnt_q >= OCW'(OUT_DEPTH - 1));
				if (issue && tap_q == 3'(CPB - 1) && band_last) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign band_last = ({1'b0, band_q} + 5'd1 == nb_q);
	assign raddr_w   = {band_q, 3'b000} - {3'b000, band_q} + {4'b0000, tap_q};
	assign waddr_w   = {qcmd.cband, 3'b000} - {3'b000, qcmd.cband} + {4'b0000, qcmd.ctap};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			band_q <= 4'd0;
			tap_q  <= 3'd0;
			nb_q   <= 5'd0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			for (int i = 0; i < TAPS; i++) begin
				win_re_q[i] <= '0;
				win_im_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (qrd && qcmd.kind == KIND_SAMPLE) begin
				win_re_q <= nwin_re;
				win_im_q <= nwin_im;
			end
			if (start) begin
				band_q <= 4'd0;
				tap_q  <= 3'd0;
				nb_q   <= nb;
			end else if (issue) begin
				if (tap_q == 3'(CPB - 1)) begin
					tap_q  <= 3'd0;
					band_q <= band_q + 4'd1;
				end else begin
					tap_q <= tap_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qrd && qcmd.kind == KIND_COEF) begin
			cmem[AW'(waddr_w)] <= {qcmd.cre, qcmd.cim};
		end
		if (issue) begin
			coef_s1 <= cmem[AW'(raddr_w)];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < PAIRS; i++) begin
				wa_re_q[i] <= nwin_re[i];
				wa_im_q[i] <= nwin_im[i];
				wz_re_q[i] <= nwin_re[TAPS - 1 - i];
				wz_im_q[i] <= nwin_im[TAPS - 1 - i];
			end
		end else if (issue && tap_q != 3'(CPB - 1)) begin
			for (int i = 0; i < PAIRS; i++) begin
				wa_re_q[i] <= wa_re_q[(i + 1) % PAIRS];
				wa_im_q[i] <= wa_im_q[(i + 1) % PAIRS];
				wz_re_q[i] <= wz_re_q[(i + 1) % PAIRS];
				wz_im_q[i] <= wz_im_q[(i + 1) % PAIRS];
			end
		end
		if (issue) begin
			first_s1 <= (tap_q == 3'd0);
			fin_s1   <= (tap_q == 3'(CPB - 1));
			cen_s1   <= (tap_q == 3'(CPB - 1));
			last_s1  <= band_last;
			band_s1  <= band_q;
			if (tap_q == 3'(CPB - 1)) begin
				sr_s1 <= 33'(win_re_q[PAIRS]);
				si_s1 <= 33'(win_im_q[PAIRS]);
				dr_s1 <= '0;
				di_s1 <= '0;
			end else begin
				sr_s1 <= 33'(wa_re_q[0]) + 33'(wz_re_q[0]);
				si_s1 <= 33'(wa_im_q[0]) + 33'(wz_im_q[0]);
				dr_s1 <= 33'(wa_re_q[0]) - 33'(wz_re_q[0]);
				di_s1 <= 33'(wa_im_q[0]) - 33'(wz_im_q[0]);
			end
		end
	end

	assign ki = cen_s1 ? 32'sd0 : $signed(coef_s1[31:0]);

	always_ff @(posedge clk) begin
		first_s2 <= first_s1;
		fin_s2   <= fin_s1;
		last_s2  <= last_s1;
		band_s2  <= band_s1;
		prr_s2   <= $signed(coef_s1[63:32]) * sr_s1;
		pri_s2   <= $signed(coef_s1[63:32]) * si_s1;
		pid_s2   <= ki * di_s1;
		pir_s2   <= ki * dr_s1;
	end

	assign acc_re_n = (first_s2 ? 64'd0 : acc_re_q) + prr_s2[63:0] - pid_s2[63:0];
	assign acc_im_n = (first_s2 ? 64'd0 : acc_im_q) + pri_s2[63:0] + pir_s2[63:0];
	assign fre      = acc_re_n + ROUND_ADD;
	assign fim      = acc_im_n + ROUND_ADD;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_re_q <= acc_re_n;
			acc_im_q <= acc_im_n;
		end
	end

	assign fpush  = v_s2 && fin_s2;
	assign fpop   = pop && !empty;
	assign empty  = (fcnt_q == '0);
	assign band   = fb_q[frp_q];
	assign out_re = fre_q[frp_q];
	assign out_im = fim_q[frp_q];
	assign last   = fl_q[frp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwp_q  <= 2'd0;
			frp_q  <= 2'd0;
			fcnt_q <= '0;
		end else begin
			if (fpush) begin
				fwp_q <= fwp_q + 2'd1;
			end
			if (fpop) begin
				frp_q <= frp_q + 2'd1;
			end
			if (fpush && !fpop) begin
				fcnt_q <= fcnt_q + OCW'(1);
			end else if (fpop && !fpush) begin
				fcnt_q <= fcnt_q - OCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fpush) begin
			fb_q[fwp_q]  <= band_s2;
			fre_q[fwp_q] <= $signed(fre[62:31]);
			fim_q[fwp_q] <= $signed(fim[62:31]);
			fl_q[fwp_q]  <= last_s2;
		end
	end

	assign stat.busy = (st_q == ST_RUN);
	assign stat.fcnt = fcnt_q;

endmodule

>>> rtl/core/hybrid_analysis_fir_bank.sv
// ---------------------------------------------------------------------------
// Hybrid analysis FIR bank
// Complex 13-tap symmetric FIR bank splitting one subband stream into
// up to MAX_BANDS hybrid bands.
// ---------------------------------------------------------------------------
// Channel   Handshake          Payload
// input     push / full        kind, sample_re, sample_im, coef_band, coef_tap,
//                              coef_re, coef_im
// result    empty / pop        band, out_re, out_im, last
// config    cfg_we             cfg_wdata (bands_in_use)
//
// A sample is read from the command queue while the back end is idle, then passes
// through the shared multiply pipeline once per band in use, one tap pair per cycle
// while the result queue has room. Its first result passes the front register, the
// queue and stages s1 and s2. The back end stores a coefficient write while idle.
// Reset clears the window and sets bands_in_use to 8; coefficients are
// undefined until written.
// A new band starts only when the result queue has room for it.
// ---------------------------------------------------------------------------
`include "hybrid_analysis_fir_bank_macros.svh"

module hybrid_analysis_fir_bank import hafb_pkg::*; #(
	parameter int MAX_BANDS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic               kind,
	input  logic signed [31:0] sample_re,
	input  logic signed [31:0] sample_im,
	input  logic [3:0]         coef_band,
	input  logic [2:0]         coef_tap,
	input  logic signed [31:0] coef_re,
	input  logic signed [31:0] coef_im,
	output logic               empty,
	input  logic               pop,
	output logic [3:0]         band,
	output logic signed [31:0] out_re,
	output logic signed [31:0] out_im,
	output logic               last
);

	logic [3:0] bands_q;
	logic       q_push, q_full, q_valid, q_rd;
	cmd_t       q_wcmd, q_rcmd;
	bstat_t     stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bands_q <= 4'd8;
		end else if (cfg_we) begin
			bands_q <= cfg_wdata;
		end
	end

	hafb_front #(.MAX_BANDS(MAX_BANDS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.sample_re (sample_re),
		.sample_im (sample_im),
		.coef_band (coef_band),
		.coef_tap  (coef_tap),
		.coef_re   (coef_re),
		.coef_im   (coef_im),
		.q_push    (q_push),
		.q_cmd     (q_wcmd),
		.q_full    (q_full)
	);

	hafb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wcmd),
		.qfull  (q_full),
		.rd     (q_rd),
		.qvalid (q_valid),
		.rdata  (q_rcmd)
	);

	hafb_back #(.MAX_BANDS(MAX_BANDS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.bands_in_use (bands_q),
		.qvalid       (q_valid),
		.qcmd         (q_rcmd),
		.qrd          (q_rd),
		.stat         (stat),
		.empty        (empty),
		.pop          (pop),
		.band         (band),
		.out_re       (out_re),
		.out_im       (out_im),
		.last         (last)
	);

	`HAFB_ASSERT_IMP(a_fifo_bound, 1'b1, stat.fcnt <= OCW'(OUT_DEPTH), "result queue overflow")
	`HAFB_ASSERT_IMP(a_band_range, !empty, {1'b0, band} < 5'(MAX_BANDS), "band out of range")
	`HAFB_ASSERT_IMP(a_last_band, !empty && !last, {1'b0, band} + 5'd1 < 5'(MAX_BANDS), "missing last")
	`HAFB_ASSERT_IMP(a_no_rd_busy, q_rd, !stat.busy, "queue read while back end busy")
	`HAFB_ASSERT_NXT(a_hold_result, !empty && !pop, !empty, "waiting result dropped")

endmodule

>>> tb/hybrid_analysis_fir_bank_test.sv
// ---------------------------------------------------------------------------
// Hybrid analysis FIR bank testbench
// Loads every coefficient, then drives directed and random samples and
// coefficient updates under random burst gaps and result stalls. Every band
// result is checked against an in-bench fixed-point filter prediction.
// ---------------------------------------------------------------------------
module hybrid_analysis_fir_bank_test import hafb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBANDS = 12;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [3:0]         band;
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               last;
	} band_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [3:0]         cfg_wdata = '0;
	logic               push = 1'b0;
	logic               full;
	logic               kind = 1'b0;
	logic signed [31:0] sample_re = '0;
	logic signed [31:0] sample_im = '0;
	logic [3:0]         coef_band = '0;
	logic [2:0]         coef_tap = '0;
	logic signed [31:0] coef_re = '0;
	logic signed [31:0] coef_im = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [3:0]         band;
	logic signed [31:0] out_re;
	logic signed [31:0] out_im;
	logic               last;

	logic signed [31:0] win_re [TAPS];
	logic signed [31:0] win_im [TAPS];
	logic signed [31:0] tap_re [NBANDS*CPB];
	logic signed [31:0] tap_im [NBANDS*CPB];
	logic [3:0]         band_count = 4'd8;
	band_result_t       expected_bands [$];
	int                 burst_left = 0;
	int                 errors = 0;
	int                 samples_sent = 0;
	int                 coefs_sent = 0;
	int                 results_seen = 0;
	int                 idle_cycles = 0;
	int                 stall_mode = 0;
	int                 stall_timer = 0;

	hybrid_analysis_fir_bank dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.push(push), .full(full), .kind(kind), .sample_re(sample_re),
		.sample_im(sample_im), .coef_band(coef_band), .coef_tap(coef_tap),
		.coef_re(coef_re), .coef_im(coef_im), .empty(empty), .pop(pop),
		.band(band), .out_re(out_re), .out_im(out_im), .last(last)
	);

	always #5 clk = ~clk;

	function automatic logic signed [31:0] round_q31(logic signed [63:0] acc);
		logic [63:0] t;
		t = acc + ROUND_ADD;
		return t[62:31];
	endfunction

	function automatic void filter_sample(logic signed [31:0] sre, logic signed [31:0] sim);
		int n;
		band_result_t r;
		logic signed [63:0] acc_re, acc_im, kr, ki, c6, a_re, a_im, z_re, z_im;
		for (int k = 0; k < TAPS - 1; k++) begin
			win_re[k] = win_re[k+1];
			win_im[k] = win_im[k+1];
		end
		win_re[TAPS-1] = sre;
		win_im[TAPS-1] = sim;
		n = (band_count > NBANDS) ? NBANDS : band_count;
		for (int b = 0; b < n; b++) begin
			c6 = tap_re[b*CPB + 6];
			a_re = win_re[6];
			a_im = win_im[6];
			acc_re = c6 * a_re;
			acc_im = c6 * a_im;
			for (int k = 0; k < PAIRS; k++) begin
				a_re = win_re[k];
				a_im = win_im[k];
				z_re = win_re[12-k];
				z_im = win_im[12-k];
				kr = tap_re[b*CPB + k];
				ki = tap_im[b*CPB + k];
				acc_re += kr * (a_re + z_re) - ki * (a_im - z_im);
				acc_im += kr * (a_im + z_im) + ki * (a_re - z_re);
			end
			r.band = 4'(b);
			r.re = round_q31(acc_re);
			r.im = round_q31(acc_im);
			r.last = (b + 1 == n);
			expected_bands.push_back(r);
		end
	endfunction

	task automatic send_item(kind_t k, logic [31:0] sre, logic [31:0] sim, logic [3:0] cb,
			logic [2:0] ct, logic [31:0] cre, logic [31:0] cim);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		push <= 1'b1;
		kind <= k;
		sample_re <= sre;
		sample_im <= sim;
		coef_band <= cb;
		coef_tap <= ct;
		coef_re <= cre;
		coef_im <= cim;
		do @(posedge clk); while (full);
		burst_left--;
		if (k == KIND_SAMPLE) begin
			filter_sample(sre, sim);
			samples_sent++;
		end else begin
			coefs_sent++;
			if (cb < NBANDS && ct < CPB) begin
				tap_re[cb*CPB + ct] = cre;
				tap_im[cb*CPB + ct] = cim;
			end
		end
	endtask

	task automatic send_sample(logic [31:0] sre, logic [31:0] sim);
		send_item(KIND_SAMPLE, sre, sim, 4'($urandom), 3'($urandom), $urandom, $urandom);
	endtask

	task automatic send_coef(logic [3:0] cb, logic [2:0] ct, logic [31:0] cre, logic [31:0] cim);
		send_item(KIND_COEF, $urandom, $urandom, cb, ct, cre, cim);
	endtask

	task automatic drain;
		push <= 1'b0;
		burst_left = 0;
		while (expected_bands.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_bands(logic [3:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		band_count = value;
	endtask

	task automatic test_coef_load;
		for (int b = 0; b < NBANDS; b++)
			for (int t = 0; t < CPB; t++)
				send_coef(4'(b), 3'(t), $urandom, $urandom);
		send_coef(4'd12, 3'd0, 32'h7fffffff, 32'h7fffffff);
		send_coef(4'd15, 3'd3, 32'h80000000, 32'h80000000);
		send_coef(4'd2, 3'd7, 32'h12345678, 32'h87654321);
	endtask

	task automatic test_extremes;
		send_coef(4'd0, 3'd0, 32'h80000000, 32'h80000000);
		send_coef(4'd0, 3'd6, 32'h80000000, 32'h7fffffff);
		send_coef(4'd1, 3'd5, 32'h7fffffff, 32'h7fffffff);
		send_coef(4'd7, 3'd6, 32'h7fffffff, 32'h80000000);
		for (int i = 0; i < 7; i++)
			send_sample(32'h80000000, 32'h80000000);
		for (int i = 0; i < 7; i++)
			send_sample(32'h7fffffff, 32'h7fffffff);
		send_sample(32'h0, 32'hffffffff);
		send_sample(32'h80000000, 32'h7fffffff);
		send_sample(32'h1, 32'h0);
	endtask

	task automatic test_band_counts;
		set_bands(4'd0);
		send_sample($urandom, $urandom);
		send_sample($urandom, $urandom);
		set_bands(4'd1);
		send_sample($urandom, $urandom);
		set_bands(4'd12);
		send_sample($urandom, $urandom);
		set_bands(4'd15);
		send_sample($urandom, $urandom);
		set_bands(4'd13);
		send_sample($urandom, $urandom);
	endtask

	task automatic test_random;
		logic [3:0] settings [6] = '{4'd3, 4'd12, 4'd1, 4'd0, 4'd14, 4'd8};
		for (int p = 0; p < 6; p++) begin
			set_bands(settings[p]);
			for (int i = 0; i < 25; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_coef(4'($urandom), 3'($urandom), $urandom, $urandom);
				else if ($urandom_range(0, 3) == 0)
					send_sample($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000,
						$urandom);
				else
					send_sample($urandom, $urandom);
			end
		end
	endtask

	always @(posedge clk) begin
		band_result_t e;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				results_seen++;
				if (expected_bands.size() == 0) begin
					$display("%0t: unexpected result band %0d re %h im %h", $time,
						band, out_re, out_im);
					errors++;
				end else begin
					e = expected_bands.pop_front();
					if (band !== e.band) begin
						$display("%0t: band expected %0d actual %0d", $time, e.band, band);
						errors++;
					end
					if (out_re !== e.re) begin
						$display("%0t: out_re expected %h actual %h", $time, e.re, out_re);
						errors++;
					end
					if (out_im !== e.im) begin
						$display("%0t: out_im expected %h actual %h", $time, e.im, out_im);
						errors++;
					end
					if (last !== e.last) begin
						$display("%0t: last expected %b actual %b", $time, e.last, last);
						errors++;
					end
				end
			end
			if (stall_timer == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_timer = $urandom_range(20, 120);
			end
			stall_timer--;
			case (stall_mode)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				default: pop <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < TAPS; k++) begin
			win_re[k] = '0;
			win_im[k] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coef_load();
		test_extremes();
		test_band_counts();
		test_random();
		drain();
		$display("Covered %0d samples and %0d coefficient transactions, %0d band results,",
			samples_sent, coefs_sent, results_seen);
		$display("with band counts from zero to saturated and random idle and stall gaps.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
